@@ design/assert_macros.svh @@
// Assertion helpers, clocked on i_clk and disabled while active-low i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cwm: assertion failed");

// Implication a |-> b on every clock edge outside reset.
`define CWM_ASSERT_IMP(lbl, a, b) \
    `CWM_ASSERT(lbl, (a) |-> (b))

`endif

@@ design/cwm_pkg.sv @@
// ---------------------------------------------------------------------------
// cwm_pkg
// Shared types, constants and tables for the cylindrical warp map.
// ---------------------------------------------------------------------------
`default_nettype none

package cwm_pkg;

    localparam int MAX_DIM        = 4096;
    localparam int OUT_FRAC_BITS  = 4;
    localparam int COEF_W         = 21;
    localparam int ROW_W          = 3 * COEF_W;
    localparam int IDX_W          = 12;
    localparam int OUT_W          = 18;
    localparam int BOUND_W        = 13;
    localparam int APB_DW         = 64;
    localparam int APB_AW         = 6;

    localparam int TWO_PI_Q       = 1647099;
    localparam int PI_Q           = 823550;
    localparam int HALF_PI_Q      = 411775;
    localparam int CORDIC_GAIN_Q  = 159188;
    localparam int CORDIC_STEPS   = 19;

    // angle / cordic datapath width, Q.18
    localparam int ANG_W = 21;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ANG_W-1:0]  t_angle;

    typedef struct packed {
        t_coef [1:0][2:0]   norm;
        t_coef [2:0][2:0]   proj;
        logic [BOUND_W-1:0] width;
        logic [BOUND_W-1:0] height;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_NORM_ROW0,
        REG_NORM_ROW1,
        REG_NORM_ROW2,
        REG_PROJ_ROW0,
        REG_PROJ_ROW1,
        REG_PROJ_ROW2,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_reg_idx;

    localparam logic signed [OUT_W-1:0] MAP_OUTSIDE = OUT_W'(-(1 <<< OUT_FRAC_BITS));

    function automatic t_angle atan_q(input int i);
        t_angle a;
        case (i)
            0:  a = 21'sd205887;
            1:  a = 21'sd121542;
            2:  a = 21'sd64220;
            3:  a = 21'sd32599;
            4:  a = 21'sd16363;
            5:  a = 21'sd8189;
            6:  a = 21'sd4096;
            7:  a = 21'sd2048;
            8:  a = 21'sd1024;
            9:  a = 21'sd512;
            10: a = 21'sd256;
            11: a = 21'sd128;
            12: a = 21'sd64;
            13: a = 21'sd32;
            14: a = 21'sd16;
            15: a = 21'sd8;
            16: a = 21'sd4;
            17: a = 21'sd2;
            18: a = 21'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ design/cwm_if.sv @@
// ---------------------------------------------------------------------------
// cwm_in_if / cwm_out_if
// Valid/ready channels for pixel requests and map results.
// ---------------------------------------------------------------------------
`default_nettype none

interface cwm_in_if;
    import cwm_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_row;
    logic [IDX_W-1:0] pixel_col;
    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface cwm_out_if;
    import cwm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] map_x;
    logic signed [OUT_W-1:0] map_y;
    modport source (output valid, output map_x, output map_y, input ready);
    modport sink   (input valid, input map_x, input map_y, output ready);
endinterface

`default_nettype wire

@@ design/cwm_core.sv @@
// ---------------------------------------------------------------------------
// cwm_core
// Pipelined datapath: normalize, angle reduce, CORDIC, project, divide, bound check.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cwm_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cwm_pkg::t_cfg i_cfg,
    cwm_in_if.sink             i_pix,
    cwm_out_if.source          o_map
);
    import cwm_pkg::*;

    localparam int N_W        = 36;
    localparam int RED_W      = 37;
    localparam int RED_SHIFT  = 14;
    localparam int RED_PER_ST = 3;
    localparam int RED_ST     = (RED_SHIFT + 1) / RED_PER_ST;
    localparam int F_W        = ANG_W + 1;
    localparam int P_W        = COEF_W + N_W;
    localparam int S_W        = P_W + 2;
    localparam int U_W        = S_W;
    localparam int Q_W        = OUT_W - 1;
    localparam int DV_W       = U_W + OUT_FRAC_BITS;
    localparam int CMP_W      = U_W + Q_W;
    localparam int DSTG       = Q_W + 1;

    localparam int ST_N  = 0;
    localparam int ST_R0 = ST_N + 1;
    localparam int ST_F  = ST_R0 + RED_ST;
    localparam int ST_C0 = ST_F + 1;
    localparam int ST_M  = ST_C0 + CORDIC_STEPS;
    localparam int ST_A  = ST_M + 1;
    localparam int ST_P  = ST_A + 1;
    localparam int ST_D0 = ST_P + 1;
    localparam int ST_O  = ST_D0 + DSTG;
    localparam int NST   = ST_O + 1;

    localparam logic signed [RED_W-1:0] TWO_PI_R = RED_W'(TWO_PI_Q);
    localparam logic signed [RED_W-1:0] RED_OFF  = TWO_PI_R <<< RED_SHIFT;

    // stage control: a stage loads when it is empty or its successor moves
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || o_map.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // normalize: n0, n1
    logic signed [N_W-1:0] r_n0;
    logic signed [N_W-1:0] r_n1 [0:ST_M-1];
    logic signed [N_W-1:0] w_n0, w_n1;
    logic signed [IDX_W:0] w_row, w_col;

    assign w_row = $signed({1'b0, i_pix.pixel_row});
    assign w_col = $signed({1'b0, i_pix.pixel_col});
    assign w_n0  = N_W'($signed(i_cfg.norm[0][0]) * w_row)
                 + N_W'($signed(i_cfg.norm[0][1]) * w_col)
                 + N_W'($signed(i_cfg.norm[0][2]));
    assign w_n1  = N_W'($signed(i_cfg.norm[1][0]) * w_row)
                 + N_W'($signed(i_cfg.norm[1][1]) * w_col)
                 + N_W'($signed(i_cfg.norm[1][2]));

    always_ff @(posedge i_clk) begin
        if (w_en[ST_N]) begin
            r_n0    <= w_n0;
            r_n1[0] <= w_n1;
        end
        for (int k = 1; k < ST_M; k++) begin
            if (w_en[k]) begin
                r_n1[k] <= r_n1[k-1];
            end
        end
    end

    // angle reduction: offset positive, then conditional subtract of 2pi << k
    logic signed [RED_W-1:0] r_red    [0:RED_ST-1];
    logic signed [RED_W-1:0] w_red_nx [0:RED_ST-1];

    always_comb begin
        logic signed [RED_W-1:0] v;
        int sh;
        for (int j = 0; j < RED_ST; j++) begin
            if (j == 0) begin
                v = RED_W'(r_n0) + RED_OFF;
            end else begin
                v = r_red[j-1];
            end
            for (int s = 0; s < RED_PER_ST; s++) begin
                sh = RED_SHIFT - RED_PER_ST * j - s;
                if (v >= (TWO_PI_R <<< sh)) begin
                    v = v - (TWO_PI_R <<< sh);
                end
            end
            w_red_nx[j] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < RED_ST; j++) begin
            if (w_en[ST_R0+j]) begin
                r_red[j] <= w_red_nx[j];
            end
        end
    end

    // fold into [-pi/2, pi/2]
    t_angle r_zf;
    logic   r_neg [0:CORDIC_STEPS];
    t_angle w_zf;
    logic   w_negf;

    always_comb begin
        logic signed [F_W-1:0] a;
        a = F_W'(r_red[RED_ST-1]);
        if (a >= F_W'(PI_Q)) begin
            a = a - F_W'(TWO_PI_Q);
        end
        w_negf = 1'b0;
        if (a > F_W'(HALF_PI_Q)) begin
            a      = F_W'(PI_Q) - a;
            w_negf = 1'b1;
        end else if (a < -F_W'(HALF_PI_Q)) begin
            a      = -F_W'(PI_Q) - a;
            w_negf = 1'b1;
        end
        w_zf = ANG_W'(a);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_F]) begin
            r_zf     <= w_zf;
            r_neg[0] <= w_negf;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (w_en[ST_C0+i]) begin
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    // rotation CORDIC, one iteration per stage
    t_angle r_cx [0:CORDIC_STEPS-1];
    t_angle r_cy [0:CORDIC_STEPS-1];
    t_angle r_cz [0:CORDIC_STEPS-1];
    t_angle w_cx [0:CORDIC_STEPS-1];
    t_angle w_cy [0:CORDIC_STEPS-1];
    t_angle w_cz [0:CORDIC_STEPS-1];

    always_comb begin
        t_angle x, y, z, dx, dy;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                x = ANG_W'(CORDIC_GAIN_Q);
                y = '0;
                z = r_zf;
            end else begin
                x = r_cx[i-1];
                y = r_cy[i-1];
                z = r_cz[i-1];
            end
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                w_cx[i] = x - dx;
                w_cy[i] = y + dy;
                w_cz[i] = z - atan_q(i);
            end else begin
                w_cx[i] = x + dx;
                w_cy[i] = y - dy;
                w_cz[i] = z + atan_q(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (w_en[ST_C0+i]) begin
                r_cx[i] <= w_cx[i];
                r_cy[i] <= w_cy[i];
                r_cz[i] <= w_cz[i];
            end
        end
    end

    // projection products, then row sums
    logic signed [P_W-1:0] r_prod [0:2][0:2];
    logic signed [S_W-1:0] r_p    [0:2];
    t_angle                w_sin, w_cos;

    assign w_sin = r_cy[CORDIC_STEPS-1];
    assign w_cos = r_neg[CORDIC_STEPS] ? -r_cx[CORDIC_STEPS-1] : r_cx[CORDIC_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_M]) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= P_W'($signed(i_cfg.proj[r][0]) * w_sin);
                r_prod[r][1] <= P_W'($signed(i_cfg.proj[r][1]) * r_n1[ST_M-1]);
                r_prod[r][2] <= P_W'($signed(i_cfg.proj[r][2]) * w_cos);
            end
        end
        if (w_en[ST_A]) begin
            for (int r = 0; r < 3; r++) begin
                r_p[r] <= S_W'(r_prod[r][0]) + S_W'(r_prod[r][1]) + S_W'(r_prod[r][2]);
            end
        end
    end

    // magnitudes and sign checks
    logic [U_W-1:0] r_unx, r_uny, r_ud;
    logic           r_badx, r_bady;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P]) begin
            r_unx  <= r_p[0][S_W-1] ? U_W'(-r_p[0]) : U_W'(r_p[0]);
            r_uny  <= r_p[1][S_W-1] ? U_W'(-r_p[1]) : U_W'(r_p[1]);
            r_ud   <= r_p[2][S_W-1] ? U_W'(-r_p[2]) : U_W'(r_p[2]);
            r_badx <= (r_p[2] == '0)
                   || ((r_p[0] != '0) && (r_p[0][S_W-1] != r_p[2][S_W-1]));
            r_bady <= (r_p[2] == '0)
                   || ((r_p[1] != '0) && (r_p[1][S_W-1] != r_p[2][S_W-1]));
        end
    end

    // restoring division, overflow check then one quotient bit per stage
    logic [DV_W-1:0] r_rx [0:DSTG-1];
    logic [DV_W-1:0] r_ry [0:DSTG-1];
    logic [Q_W-1:0]  r_qx [0:DSTG-1];
    logic [Q_W-1:0]  r_qy [0:DSTG-1];
    logic            r_ox [0:DSTG-1];
    logic            r_oy [0:DSTG-1];
    logic [U_W-1:0]  r_dd [0:DSTG-1];
    logic [DV_W-1:0] w_rx [1:DSTG-1];
    logic [DV_W-1:0] w_ry [1:DSTG-1];
    logic [Q_W-1:0]  w_qx [1:DSTG-1];
    logic [Q_W-1:0]  w_qy [1:DSTG-1];
    logic [DV_W-1:0] w_dx0, w_dy0;
    logic [CMP_W-1:0] w_lim0;

    assign w_dx0  = {r_unx, OUT_FRAC_BITS'(0)};
    assign w_dy0  = {r_uny, OUT_FRAC_BITS'(0)};
    assign w_lim0 = CMP_W'(r_ud) << Q_W;

    always_comb begin
        logic [CMP_W-1:0] dsh;
        int j;
        for (int t = 1; t < DSTG; t++) begin
            j   = Q_W - t;
            dsh = CMP_W'(r_dd[t-1]) << j;
            w_rx[t] = r_rx[t-1];
            w_qx[t] = r_qx[t-1];
            if (CMP_W'(r_rx[t-1]) >= dsh) begin
                w_rx[t]    = DV_W'(CMP_W'(r_rx[t-1]) - dsh);
                w_qx[t][j] = 1'b1;
            end
            w_ry[t] = r_ry[t-1];
            w_qy[t] = r_qy[t-1];
            if (CMP_W'(r_ry[t-1]) >= dsh) begin
                w_ry[t]    = DV_W'(CMP_W'(r_ry[t-1]) - dsh);
                w_qy[t][j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D0]) begin
            r_rx[0] <= w_dx0;
            r_ry[0] <= w_dy0;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_ox[0] <= r_badx || (CMP_W'(w_dx0) >= w_lim0);
            r_oy[0] <= r_bady || (CMP_W'(w_dy0) >= w_lim0);
            r_dd[0] <= r_ud;
        end
        for (int t = 1; t < DSTG; t++) begin
            if (w_en[ST_D0+t]) begin
                r_rx[t] <= w_rx[t];
                r_ry[t] <= w_ry[t];
                r_qx[t] <= w_qx[t];
                r_qy[t] <= w_qy[t];
                r_ox[t] <= r_ox[t-1];
                r_oy[t] <= r_oy[t-1];
                r_dd[t] <= r_dd[t-1];
            end
        end
    end

    // bound check and output register
    logic signed [OUT_W-1:0] r_mx, r_my;
    logic [BOUND_W-1:0]      w_bw, w_bh;
    logic [Q_W-1:0]          w_bw16, w_bh16;
    logic                    w_outx, w_outy;

    assign w_bw   = (i_cfg.width  > BOUND_W'(MAX_DIM)) ? BOUND_W'(MAX_DIM) : i_cfg.width;
    assign w_bh   = (i_cfg.height > BOUND_W'(MAX_DIM)) ? BOUND_W'(MAX_DIM) : i_cfg.height;
    assign w_bw16 = Q_W'(w_bw) << OUT_FRAC_BITS;
    assign w_bh16 = Q_W'(w_bh) << OUT_FRAC_BITS;
    assign w_outx = r_ox[DSTG-1] || (r_qx[DSTG-1] > w_bw16)
                 || ((r_qx[DSTG-1] == w_bw16) && (r_rx[DSTG-1] != '0));
    assign w_outy = r_oy[DSTG-1] || (r_qy[DSTG-1] > w_bh16)
                 || ((r_qy[DSTG-1] == w_bh16) && (r_ry[DSTG-1] != '0));

    always_ff @(posedge i_clk) begin
        if (w_en[ST_O]) begin
            r_mx <= w_outx ? MAP_OUTSIDE : $signed({1'b0, r_qx[DSTG-1]});
            r_my <= w_outy ? MAP_OUTSIDE : $signed({1'b0, r_qy[DSTG-1]});
        end
    end

    assign o_map.valid = r_v[ST_O];
    assign o_map.map_x = r_mx;
    assign o_map.map_y = r_my;

    // input stalls only when every stage holds an item
    `CWM_ASSERT_IMP(a_full_when_stalled, !w_en[0], &r_v)
    // folded angle lies inside the CORDIC range
    `CWM_ASSERT_IMP(a_fold_range, r_v[ST_F],
        (r_zf <= ANG_W'(HALF_PI_Q)) && (r_zf >= -ANG_W'(HALF_PI_Q)))
    // rotation has converged by the last iteration
    `CWM_ASSERT_IMP(a_cordic_conv, r_v[ST_M-1],
        (r_cz[CORDIC_STEPS-1] < 21'sd1024) && (r_cz[CORDIC_STEPS-1] > -21'sd1024))

endmodule

`default_nettype wire

@@ design/cylindrical_warp_map.sv @@
// ---------------------------------------------------------------------------
// cylindrical_warp_map
// Cylindrical projection warp map generator with APB register port.
// ---------------------------------------------------------------------------
// Takes one pixel request (row, col) per clock unless the output
// stalls, and returns the source coordinate in sixteenths of a pixel,
// or -16 where it falls outside the image. The pipeline depth is set
// mostly by the 19-stage sin/cos CORDIC and the 18-stage restoring
// dividers (one per output coordinate). Registers are written through
// APB at byte address 8*index; write them only while the pipeline
// is empty.
`default_nettype none

module cylindrical_warp_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    cwm_in_if.sink                          i_pix,
    cwm_out_if.source                       o_map,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cwm_pkg::APB_AW-1:0] paddr,
    input  wire logic [cwm_pkg::APB_DW-1:0] pwdata,
    output logic      [cwm_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import cwm_pkg::*;

    logic [ROW_W-1:0]   r_row [0:5];
    logic [BOUND_W-1:0] r_width, r_height;
    t_reg_idx           w_idx;
    t_cfg               w_cfg;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_row[k] <= '0;
            end
            r_width  <= BOUND_W'(4096);
            r_height <= BOUND_W'(4096);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_NORM_ROW0:    r_row[0] <= pwdata[ROW_W-1:0];
                REG_NORM_ROW1:    r_row[1] <= pwdata[ROW_W-1:0];
                REG_NORM_ROW2:    r_row[2] <= pwdata[ROW_W-1:0];
                REG_PROJ_ROW0:    r_row[3] <= pwdata[ROW_W-1:0];
                REG_PROJ_ROW1:    r_row[4] <= pwdata[ROW_W-1:0];
                REG_PROJ_ROW2:    r_row[5] <= pwdata[ROW_W-1:0];
                REG_IMAGE_WIDTH:  r_width  <= pwdata[BOUND_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NORM_ROW0:    prdata = APB_DW'(r_row[0]);
            REG_NORM_ROW1:    prdata = APB_DW'(r_row[1]);
            REG_NORM_ROW2:    prdata = APB_DW'(r_row[2]);
            REG_PROJ_ROW0:    prdata = APB_DW'(r_row[3]);
            REG_PROJ_ROW1:    prdata = APB_DW'(r_row[4]);
            REG_PROJ_ROW2:    prdata = APB_DW'(r_row[5]);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_height);
            default:          prdata = '0;
        endcase
    end

    // unpack coefficient k of each row from bits [21k+20 : 21k]
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_cfg.norm[r][k] = r_row[r][COEF_W*k +: COEF_W];
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_cfg.proj[r][k] = r_row[3+r][COEF_W*k +: COEF_W];
            end
        end
        w_cfg.width  = r_width;
        w_cfg.height = r_height;
    end

    cwm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pix   (i_pix),
        .o_map   (o_map)
    );

endmodule

`default_nettype wire
